// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define BCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg
// types, codes and helper functions of the button click classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 16;
    localparam int TIP_W  = 3;
    localparam int REP_W  = 8;

    // standard machine phases, code 10 is not used
    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_FIRST_PRESS  = 4'd1,
        PH_PRESS_HELD   = 4'd2,
        PH_HOLD         = 4'd3,
        PH_TIP_WAIT     = 4'd4,
        PH_CLICK_PAUSE  = 4'd5,
        PH_SECOND_PRESS = 4'd6,
        PH_SECOND_LONG  = 4'd7,
        PH_WAIT_RELEASE = 4'd8,
        PH_SECOND_PAUSE = 4'd9,
        PH_LOCAL_DIM    = 4'd11,
        PH_THIRD_PRESS  = 4'd12,
        PH_THIRD_LONG   = 4'd13,
        PH_HOLD_DONE    = 4'd14
    } phase_t;

    localparam logic [4:0] EV_TIP1             = 5'd0;
    localparam logic [4:0] EV_TIP4             = 5'd3;
    localparam logic [4:0] EV_CLICK1           = 5'd4;
    localparam logic [4:0] EV_CLICK2           = 5'd5;
    localparam logic [4:0] EV_CLICK3           = 5'd6;
    localparam logic [4:0] EV_SHORT_LONG       = 5'd7;
    localparam logic [4:0] EV_SHORT_SHORT_LONG = 5'd8;
    localparam logic [4:0] EV_HOLD_START       = 5'd9;
    localparam logic [4:0] EV_HOLD_REPEAT      = 5'd10;
    localparam logic [4:0] EV_HOLD_END         = 5'd11;
    localparam logic [4:0] EV_LOCAL_ON         = 5'd12;
    localparam logic [4:0] EV_LOCAL_OFF        = 5'd13;
    localparam logic [4:0] EV_DIM_UP           = 5'd14;
    localparam logic [4:0] EV_DIM_DOWN         = 5'd15;
    localparam logic [4:0] EV_DIM_STOP         = 5'd16;
    localparam logic [4:0] EV_COMPLETE         = 5'd17;

    localparam logic [1:0] MODE_STANDARD = 2'd0;
    localparam logic [1:0] MODE_SIMPLE   = 2'd1;
    localparam logic [1:0] MODE_DIMMER   = 2'd2;

    localparam logic [1:0] ROCKER_DOWN = 2'd1;
    localparam logic [1:0] ROCKER_UP   = 2'd2;

    localparam logic [1:0] PEND_NONE     = 2'd0;
    localparam logic [1:0] PEND_COMPLETE = 2'd1;
    localparam logic [1:0] PEND_REPEAT   = 2'd2;

    localparam logic [2:0] REG_CLICK_LEN    = 3'd0;
    localparam logic [2:0] REG_CLICK_PAUSE  = 3'd1;
    localparam logic [2:0] REG_TIP_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_LONG_PRESS   = 3'd3;
    localparam logic [2:0] REG_REPEAT_INTVL = 3'd4;
    localparam logic [2:0] REG_MODE         = 3'd5;
    localparam logic [2:0] REG_LOCAL_EN     = 3'd6;
    localparam logic [2:0] REG_ROCKER       = 3'd7;

    localparam logic [CFG_W-1:0] RST_CLICK_LEN    = 16'd14;
    localparam logic [CFG_W-1:0] RST_CLICK_PAUSE  = 16'd14;
    localparam logic [CFG_W-1:0] RST_TIP_TIMEOUT  = 16'd80;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS   = 16'd50;
    localparam logic [CFG_W-1:0] RST_REPEAT_INTVL = 16'd100;

    localparam logic [TIP_W-1:0] TIP_MAX    = 3'd4;
    localparam logic [REP_W-1:0] REPEAT_CAP = 8'd255;

    typedef struct packed {
        logic [CFG_W-1:0] click_len;
        logic [CFG_W-1:0] click_pause;
        logic [CFG_W-1:0] tip_timeout;
        logic [CFG_W-1:0] long_press;
        logic [CFG_W-1:0] repeat_intvl;
        logic [1:0]       mode;
        logic             local_en;
        logic [1:0]       rocker;
    } cfg_t;

    // timer against threshold compares
    typedef struct packed {
        logic clen_ge;
        logic clen_gt;
        logic pause_ge;
        logic tip_ge;
        logic long_ge;
        logic long_gt;
        logic rep_ge;
    } cmp_t;

    typedef struct packed {
        phase_t           phase;
        logic             rel;
        logic             prs;
        logic             loc;
        logic             on;
        logic [1:0]       rocker;
        logic             dim_up;
        logic [TIP_W-1:0] tip_count;
        logic             rep_below_max;
        cmp_t             cmp;
    } std_in_t;

    typedef struct packed {
        logic             ev_valid;
        logic [4:0]       ev_code;
        logic             restart;
        logic             stop_timer;
        logic             tip_load;
        logic [TIP_W-1:0] tip_value;
        logic             rep_clear;
        logic             rep_inc;
        logic             dim_toggle;
    } std_act_t;

    function automatic logic [4:0] local_switch_code(input logic [1:0] rocker,
                                                      input logic on);
        if (rocker == ROCKER_DOWN) return EV_LOCAL_OFF;
        if (rocker == ROCKER_UP) return EV_LOCAL_ON;
        return on ? EV_LOCAL_OFF : EV_LOCAL_ON;
    endfunction

    // single button alternates direction, flag holds the previous direction
    function automatic logic [4:0] dim_start_code(input logic [1:0] rocker,
                                                   input logic dim_up);
        if (rocker == ROCKER_DOWN) return EV_DIM_DOWN;
        if (rocker == ROCKER_UP) return EV_DIM_UP;
        return dim_up ? EV_DIM_DOWN : EV_DIM_UP;
    endfunction

    function automatic logic dim_toggles(input logic [1:0] rocker);
        return (rocker != ROCKER_DOWN) && (rocker != ROCKER_UP);
    endfunction

    function automatic logic [4:0] tip_code(input logic [TIP_W-1:0] n);
        if (n == '0) return EV_TIP1;
        if (n > TIP_MAX) return EV_TIP4;
        return EV_TIP1 + 5'(n - 3'd1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bcc_regs.sv -----
// ----------------------------------------------------------------------------
// bcc_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_regs
    import bcc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [CFG_W-1:0] click_len_reg;
    logic [CFG_W-1:0] click_pause_reg;
    logic [CFG_W-1:0] tip_timeout_reg;
    logic [CFG_W-1:0] long_press_reg;
    logic [CFG_W-1:0] repeat_intvl_reg;
    logic [1:0]       mode_reg;
    logic             local_en_reg;
    logic [1:0]       rocker_reg;
    logic             wr_en;
    logic [2:0]       reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            click_len_reg    <= RST_CLICK_LEN;
            click_pause_reg  <= RST_CLICK_PAUSE;
            tip_timeout_reg  <= RST_TIP_TIMEOUT;
            long_press_reg   <= RST_LONG_PRESS;
            repeat_intvl_reg <= RST_REPEAT_INTVL;
            mode_reg         <= MODE_STANDARD;
            local_en_reg     <= 1'b0;
            rocker_reg       <= 2'd0;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_CLICK_LEN:    click_len_reg    <= pwdata[CFG_W-1:0];
                REG_CLICK_PAUSE:  click_pause_reg  <= pwdata[CFG_W-1:0];
                REG_TIP_TIMEOUT:  tip_timeout_reg  <= pwdata[CFG_W-1:0];
                REG_LONG_PRESS:   long_press_reg   <= pwdata[CFG_W-1:0];
                REG_REPEAT_INTVL: repeat_intvl_reg <= pwdata[CFG_W-1:0];
                REG_MODE:         mode_reg         <= pwdata[1:0];
                REG_LOCAL_EN:     local_en_reg     <= pwdata[0];
                REG_ROCKER:       rocker_reg       <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_CLICK_LEN:    prdata = DATA_W'(click_len_reg);
            REG_CLICK_PAUSE:  prdata = DATA_W'(click_pause_reg);
            REG_TIP_TIMEOUT:  prdata = DATA_W'(tip_timeout_reg);
            REG_LONG_PRESS:   prdata = DATA_W'(long_press_reg);
            REG_REPEAT_INTVL: prdata = DATA_W'(repeat_intvl_reg);
            REG_MODE:         prdata = DATA_W'(mode_reg);
            REG_LOCAL_EN:     prdata = DATA_W'(local_en_reg);
            REG_ROCKER:       prdata = DATA_W'(rocker_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.click_len    = click_len_reg;
    assign cfg.click_pause  = click_pause_reg;
    assign cfg.tip_timeout  = tip_timeout_reg;
    assign cfg.long_press   = long_press_reg;
    assign cfg.repeat_intvl = repeat_intvl_reg;
    assign cfg.mode         = mode_reg;
    assign cfg.local_en     = local_en_reg;
    assign cfg.rocker       = rocker_reg;

endmodule

`default_nettype wire

// ----- rtl/bcc_std_fsm.sv -----
// ----------------------------------------------------------------------------
// bcc_std_fsm
// standard mode click machine: phase transitions and actions
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_std_fsm
    import bcc_pkg::*;
(
    input  std_in_t  si,
    output phase_t   phase_next,
    output std_act_t act
);

    always_comb begin
        phase_next = si.phase;
        unique case (si.phase)
            PH_IDLE: begin
                if (si.prs) phase_next = PH_FIRST_PRESS;
            end
            PH_FIRST_PRESS: begin
                if (si.rel) phase_next = PH_CLICK_PAUSE;
                else if (si.cmp.clen_ge) phase_next = PH_PRESS_HELD;
            end
            PH_PRESS_HELD: begin
                if (si.rel) phase_next = PH_TIP_WAIT;
                else if (si.cmp.long_ge) begin
                    phase_next = (!si.loc || !si.on) ? PH_HOLD : PH_LOCAL_DIM;
                end
            end
            PH_HOLD: begin
                if (si.rel) phase_next = PH_IDLE;
                else if (si.cmp.rep_ge && !si.rep_below_max) phase_next = PH_HOLD_DONE;
            end
            PH_TIP_WAIT: begin
                if (si.prs) phase_next = PH_PRESS_HELD;
                else if (si.cmp.tip_ge) phase_next = PH_IDLE;
            end
            PH_CLICK_PAUSE: begin
                if (si.prs) phase_next = PH_SECOND_PRESS;
                else if (si.cmp.pause_ge) phase_next = PH_TIP_WAIT;
            end
            PH_SECOND_PRESS: begin
                if (si.rel) phase_next = PH_SECOND_PAUSE;
                else if (si.cmp.clen_gt) phase_next = PH_SECOND_LONG;
            end
            PH_SECOND_LONG: begin
                if (si.rel) phase_next = PH_TIP_WAIT;
                else if (si.cmp.long_gt) phase_next = PH_WAIT_RELEASE;
            end
            PH_WAIT_RELEASE: begin
                if (si.rel) phase_next = PH_IDLE;
            end
            PH_SECOND_PAUSE: begin
                if (si.prs) phase_next = PH_THIRD_PRESS;
                else if (si.cmp.pause_ge) phase_next = PH_TIP_WAIT;
            end
            PH_LOCAL_DIM: begin
                if (si.rel) phase_next = PH_IDLE;
            end
            PH_THIRD_PRESS: begin
                if (si.rel) phase_next = PH_TIP_WAIT;
                else if (si.cmp.clen_ge) phase_next = PH_THIRD_LONG;
            end
            PH_THIRD_LONG: begin
                if (si.rel) phase_next = PH_TIP_WAIT;
                else if (si.cmp.long_ge) phase_next = PH_WAIT_RELEASE;
            end
            PH_HOLD_DONE: begin
                if (si.rel) phase_next = PH_IDLE;
            end
            default: phase_next = si.phase;
        endcase
    end

    always_comb begin
        act = '0;
        unique case (si.phase)
            PH_IDLE: begin
                act.stop_timer = 1'b1;
                if (si.prs) begin
                    act.tip_load  = 1'b1;
                    act.tip_value = si.loc ? 3'd0 : 3'd1;
                    act.restart   = 1'b1;
                end
            end
            PH_FIRST_PRESS: begin
                if (si.rel) act.restart = 1'b1;
            end
            PH_PRESS_HELD: begin
                if (si.rel) begin
                    act.restart  = 1'b1;
                    act.ev_valid = 1'b1;
                    if (si.tip_count == '0) begin
                        act.ev_code   = local_switch_code(si.rocker, si.on);
                        act.tip_load  = 1'b1;
                        act.tip_value = 3'd1;
                    end else begin
                        act.ev_code = tip_code(si.tip_count);
                    end
                end else if (si.cmp.long_ge) begin
                    act.ev_valid = 1'b1;
                    if (!si.loc || !si.on) begin
                        act.rep_clear = 1'b1;
                        act.restart   = 1'b1;
                        act.ev_code   = EV_HOLD_START;
                    end else begin
                        act.ev_code    = dim_start_code(si.rocker, si.dim_up);
                        act.dim_toggle = dim_toggles(si.rocker);
                    end
                end
            end
            PH_HOLD: begin
                if (si.rel) begin
                    act.ev_valid = 1'b1;
                    act.ev_code  = EV_HOLD_END;
                end else if (si.cmp.rep_ge) begin
                    act.ev_valid = 1'b1;
                    if (si.rep_below_max) begin
                        act.restart = 1'b1;
                        act.rep_inc = 1'b1;
                        act.ev_code = EV_HOLD_REPEAT;
                    end else begin
                        act.ev_code = EV_HOLD_END;
                    end
                end
            end
            PH_TIP_WAIT: begin
                if (si.prs) begin
                    act.restart   = 1'b1;
                    act.tip_load  = 1'b1;
                    act.tip_value = (si.tip_count >= TIP_MAX) ? 3'd2 : si.tip_count + 3'd1;
                end else if (si.cmp.tip_ge) begin
                    act.ev_valid = 1'b1;
                    act.ev_code  = EV_COMPLETE;
                end
            end
            PH_CLICK_PAUSE: begin
                if (si.prs) begin
                    act.restart   = 1'b1;
                    act.tip_load  = 1'b1;
                    act.tip_value = 3'd2;
                end else if (si.cmp.pause_ge) begin
                    act.ev_valid = 1'b1;
                    act.ev_code  = si.loc ? local_switch_code(si.rocker, si.on) : EV_CLICK1;
                end
            end
            PH_SECOND_PRESS: begin
                if (si.rel) act.restart = 1'b1;
            end
            PH_SECOND_LONG: begin
                if (si.rel) begin
                    act.restart  = 1'b1;
                    act.ev_valid = 1'b1;
                    act.ev_code  = tip_code(3'd2);
                end else if (si.cmp.long_gt) begin
                    act.ev_valid = 1'b1;
                    act.ev_code  = EV_SHORT_LONG;
                end
            end
            PH_WAIT_RELEASE: begin
                if (si.rel) begin
                    act.ev_valid = 1'b1;
                    act.ev_code  = EV_COMPLETE;
                end
            end
            PH_SECOND_PAUSE: begin
                if (si.prs) begin
                    act.restart   = 1'b1;
                    act.tip_load  = 1'b1;
                    act.tip_value = 3'd3;
                end else if (si.cmp.pause_ge) begin
                    act.ev_valid = 1'b1;
                    act.ev_code  = EV_CLICK2;
                end
            end
            PH_LOCAL_DIM: begin
                if (si.rel) begin
                    act.ev_valid = 1'b1;
                    act.ev_code  = EV_DIM_STOP;
                end
            end
            PH_THIRD_PRESS: begin
                if (si.rel) begin
                    act.restart  = 1'b1;
                    act.ev_valid = 1'b1;
                    act.ev_code  = EV_CLICK3;
                end
            end
            PH_THIRD_LONG: begin
                if (si.rel) begin
                    act.restart  = 1'b1;
                    act.ev_valid = 1'b1;
                    act.ev_code  = tip_code(3'd3);
                end else if (si.cmp.long_ge) begin
                    act.ev_valid = 1'b1;
                    act.ev_code  = EV_SHORT_SHORT_LONG;
                end
            end
            default: act = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/bcc_core.sv -----
// ----------------------------------------------------------------------------
// bcc_core
// classifier state and the update that one item makes to it
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bcc_core
    import bcc_pkg::*;
#(
    parameter int MAX_REPEATS      = 30,
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic       kind,
    input  wire logic       pressed,
    input  wire logic       output_on,
    input  cfg_t            cfg,
    output logic            ev_valid,
    output logic [4:0]      ev_code
);

    localparam int TW = TICK_COUNT_WIDTH;
    localparam int CW = (TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W;

    phase_t           phase_reg, phase_next;
    logic [TW-1:0]    elapsed_reg, elapsed_next;
    logic             running_reg, running_next;
    logic [TIP_W-1:0] tip_reg, tip_next;
    logic [REP_W-1:0] rep_reg, rep_next;
    logic             dim_up_reg, dim_up_next;
    logic             level_reg, level_next;
    logic [1:0]       pend_reg, pend_next;
    logic [TW-1:0]    pend_ticks_reg, pend_ticks_next;

    logic [TW-1:0]    el_inc;
    logic [TW-1:0]    pend_inc;
    logic [TW-1:0]    t_now;
    logic [CW-1:0]    t_ext;
    logic [CW-1:0]    pend_ext;
    logic [REP_W-1:0] rep_sat;
    logic             lvl_now;
    logic             chg;
    logic             tip_gt;
    logic [TIP_W-1:0] tc0;
    logic [TIP_W:0]   tc_inc;
    logic             simple_tip;
    std_in_t          si;
    phase_t           std_phase_next;
    std_act_t         act;

    assign el_inc   = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign pend_inc = (pend_ticks_reg == '1) ? pend_ticks_reg : pend_ticks_reg + 1'b1;
    assign rep_sat  = (rep_reg < REPEAT_CAP) ? rep_reg + 1'b1 : rep_reg;

    // a timer that is not running reads as saturated
    assign t_now    = running_reg ? (kind ? el_inc : elapsed_reg) : '1;
    assign t_ext    = CW'(t_now);
    assign pend_ext = CW'(pend_inc);

    assign lvl_now = kind ? level_reg : pressed;
    assign chg     = !kind && (pressed != level_reg);
    assign tip_gt  = t_ext > CW'(cfg.tip_timeout);

    assign si.phase         = phase_reg;
    assign si.rel           = chg && !lvl_now;
    assign si.prs           = chg && lvl_now;
    assign si.loc           = cfg.local_en;
    assign si.on            = output_on;
    assign si.rocker        = cfg.rocker;
    assign si.dim_up        = dim_up_reg;
    assign si.tip_count     = tip_reg;
    assign si.rep_below_max = rep_reg < REP_W'(MAX_REPEATS);
    assign si.cmp.clen_ge   = t_ext >= CW'(cfg.click_len);
    assign si.cmp.clen_gt   = t_ext >  CW'(cfg.click_len);
    assign si.cmp.pause_ge  = t_ext >= CW'(cfg.click_pause);
    assign si.cmp.tip_ge    = t_ext >= CW'(cfg.tip_timeout);
    assign si.cmp.long_ge   = t_ext >= CW'(cfg.long_press);
    assign si.cmp.long_gt   = t_ext >  CW'(cfg.long_press);
    assign si.cmp.rep_ge    = t_ext >= CW'(cfg.repeat_intvl);

    bcc_std_fsm u_std_fsm (
        .si         (si),
        .phase_next (std_phase_next),
        .act        (act)
    );

    // simple mode tip counting
    assign tc0    = tip_gt ? '0 : tip_reg;
    assign tc_inc = {1'b0, tc0} + 1'b1;

    always_comb begin
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        running_next    = running_reg;
        tip_next        = tip_reg;
        rep_next        = rep_reg;
        dim_up_next     = dim_up_reg;
        level_next      = level_reg;
        pend_next       = pend_reg;
        pend_ticks_next = pend_ticks_reg;
        ev_valid        = 1'b0;
        ev_code         = EV_TIP1;
        simple_tip      = 1'b0;

        if (step) begin
            if (kind) begin
                if (running_reg) elapsed_next = el_inc;
            end else begin
                level_next = pressed;
            end

            if (kind && pend_reg != PEND_NONE) begin
                // a pending action takes the tick on its own
                pend_ticks_next = pend_inc;
                case (pend_reg)
                    PEND_COMPLETE: begin
                        if (pend_ext >= CW'(cfg.tip_timeout)) begin
                            pend_next = PEND_NONE;
                            ev_valid  = 1'b1;
                            ev_code   = EV_COMPLETE;
                        end
                    end
                    PEND_REPEAT: begin
                        if (pend_ext >= CW'(cfg.repeat_intvl)) begin
                            pend_ticks_next = '0;
                            rep_next        = rep_sat;
                            if (rep_sat >= REP_W'(MAX_REPEATS)) pend_next = PEND_NONE;
                            ev_valid = 1'b1;
                            ev_code  = EV_HOLD_REPEAT;
                        end
                    end
                    default: pend_next = PEND_NONE;
                endcase
            end else if (cfg.mode == MODE_STANDARD && (!kind || running_reg)) begin
                pend_next  = PEND_NONE;
                phase_next = std_phase_next;
                if (act.stop_timer) running_next = 1'b0;
                if (act.restart) begin
                    elapsed_next = '0;
                    running_next = 1'b1;
                end
                if (act.tip_load) tip_next = act.tip_value;
                if (act.rep_clear) rep_next = '0;
                if (act.rep_inc) rep_next = rep_reg + 1'b1;
                if (act.dim_toggle) dim_up_next = !dim_up_reg;
                ev_valid = act.ev_valid;
                ev_code  = act.ev_code;
            end else if (!kind) begin
                if (cfg.mode == MODE_SIMPLE) begin
                    tip_next = tc0;
                    if (lvl_now) begin
                        simple_tip = 1'b1;
                        phase_next = PH_WAIT_RELEASE;
                    end else if (phase_reg == PH_IDLE) begin
                        // release seen without its press
                        simple_tip      = 1'b1;
                        pend_next       = PEND_COMPLETE;
                        pend_ticks_next = '0;
                    end else begin
                        phase_next = PH_IDLE;
                        ev_valid   = 1'b1;
                        ev_code    = EV_COMPLETE;
                    end
                    if (simple_tip) begin
                        ev_valid = 1'b1;
                        if (cfg.local_en && tc0 == '0) begin
                            ev_code = local_switch_code(cfg.rocker, output_on);
                        end else begin
                            ev_code  = EV_TIP1 + 5'(tc0[1:0]);
                            tip_next = (tc_inc >= {1'b0, TIP_MAX}) ? '0 : tc_inc[TIP_W-1:0];
                        end
                    end
                end else if (cfg.mode == MODE_DIMMER && chg) begin
                    ev_valid = 1'b1;
                    if (cfg.local_en && output_on) begin
                        if (lvl_now) begin
                            ev_code = dim_start_code(cfg.rocker, dim_up_reg);
                            if (dim_toggles(cfg.rocker)) dim_up_next = !dim_up_reg;
                        end else begin
                            ev_code = EV_DIM_STOP;
                        end
                    end else if (lvl_now) begin
                        rep_next        = '0;
                        pend_next       = PEND_REPEAT;
                        pend_ticks_next = '0;
                        ev_code         = EV_HOLD_START;
                    end else begin
                        pend_next = PEND_NONE;
                        ev_code   = EV_HOLD_END;
                    end
                end
                elapsed_next = '0;
                running_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            elapsed_reg    <= '0;
            running_reg    <= 1'b0;
            tip_reg        <= '0;
            rep_reg        <= '0;
            dim_up_reg     <= 1'b0;
            level_reg      <= 1'b0;
            pend_reg       <= PEND_NONE;
            pend_ticks_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            running_reg    <= running_next;
            tip_reg        <= tip_next;
            rep_reg        <= rep_next;
            dim_up_reg     <= dim_up_next;
            level_reg      <= level_next;
            pend_reg       <= pend_next;
            pend_ticks_reg <= pend_ticks_next;
        end
    end

    `BCC_ASSERT(a_rep_bounded, aclk, aresetn, rep_reg <= REP_W'(MAX_REPEATS), "repeat count above limit")
    `BCC_ASSERT(a_tip_bounded, aclk, aresetn, tip_reg <= TIP_MAX, "tip count above four")
    `BCC_ASSERT_IMPL(a_repeat_pending_dimmer, aclk, aresetn, step && !kind && cfg.mode == MODE_DIMMER && chg && lvl_now && !(cfg.local_en && output_on), ev_valid && ev_code == EV_HOLD_START && pend_next == PEND_REPEAT, "press in dimmer mode did not start hold")

endmodule

`default_nettype wire

// ----- rtl/button_click_classifier.sv -----
// path: the item is held in the input register, its result in the result register
// throughput: one item per cycle while the result register is free or drained
// items that cause no event leave no result but still step the click state
// reset: synchronous active-low aresetn clears the click state, the valid flags of
// both item registers and the configuration to its defaults
// ----------------------------------------------------------------------------
// button_click_classifier
// push button click classifier with input and result registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int MAX_REPEATS      = 30,
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_kind,
    input  wire logic              s_pressed,
    input  wire logic              s_output_on,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [4:0]        m_event_code,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t       cfg;
    logic       in_valid_reg, in_valid_next;
    logic       kind_reg;
    logic       pressed_reg;
    logic       on_reg;
    logic       m_valid_reg, m_valid_next;
    logic [4:0] m_event_code_reg;
    logic       advance;
    logic       in_take;
    logic       ev_valid;
    logic [4:0] ev_code;

    bcc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcc_core #(
        .MAX_REPEATS      (MAX_REPEATS),
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .kind      (kind_reg),
        .pressed   (pressed_reg),
        .output_on (on_reg),
        .cfg       (cfg),
        .ev_valid  (ev_valid),
        .ev_code   (ev_code)
    );

    // the held item moves on when the result register is free or being drained
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (advance) m_valid_next = ev_valid;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            kind_reg    <= s_kind;
            pressed_reg <= s_pressed;
            on_reg      <= s_output_on;
        end
        if (advance && ev_valid) m_event_code_reg <= ev_code;
    end

    assign m_valid      = m_valid_reg;
    assign m_event_code = m_event_code_reg;

    `BCC_ASSERT_NEXT(a_event_lands, aclk, aresetn, advance && ev_valid, m_valid_reg && m_event_code_reg == $past(ev_code), "event lost on way to result register")
    `BCC_ASSERT_NEXT(a_item_kept, aclk, aresetn, in_valid_reg && !advance, in_valid_reg, "held item dropped")
    `BCC_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, m_valid_reg && !m_ready, !advance, "result overwritten while stalled")

endmodule

`default_nettype wire
